FILE: rtl/assert_macros.svh
// assertion macros used by integer_to_radix_digits
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define ITRD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define ITRD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ITRD_ASSERT_IMP(label, clk, rst, ante, cons)
`define ITRD_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/itrd_pkg.sv
// shared constants, types and digit encoding for the radix digit converter
package itrd_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int VALUE_W        = 64;
  localparam int RADIX_W        = 5;
  localparam int DIGIT_W        = 4;
  localparam int CHAR_W         = 7;
  localparam int LEN_W          = 7;
  localparam int STEP_BITS      = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 4'd10;

  // divider control from the sequencer
  typedef struct packed {
    logic start;
    logic load;
  } div_ctrl_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic done;
    logic zero;
  } div_stat_t;

  // ascii character of one digit
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d,
                                                       input logic upper);
    logic [CHAR_W-1:0] letter_base;
    letter_base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
    if (d < DIGIT_TEN) begin
      return CHAR_ZERO + CHAR_W'(d);
    end else begin
      return letter_base + CHAR_W'(d - DIGIT_TEN);
    end
  endfunction

endpackage

FILE: rtl/itrd_div_unit.sv
// iterative small-divisor divider, eight quotient bits per cycle
module itrd_div_unit #(
  parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  itrd_pkg::div_ctrl_t            ctrl,
  input  logic [VALUE_BITS-1:0]          value_in,
  input  logic [itrd_pkg::RADIX_W-1:0]   radix_in,
  output itrd_pkg::div_stat_t            stat,
  output logic [itrd_pkg::DIGIT_W-1:0]   digit
);
  import itrd_pkg::*;

  localparam int CHUNKS   = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_BITS = CHUNKS * STEP_BITS;
  localparam int CNT_W    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  logic [PAD_BITS-1:0]  work;
  logic [PAD_BITS-1:0]  work_next;
  logic [DIGIT_W-1:0]   rem;
  logic [RADIX_W-1:0]   radix;
  logic [CNT_W-1:0]     cnt;
  logic                 active;
  logic                 done;
  logic [DIGIT_W-1:0]   part;
  logic [RADIX_W-1:0]   trial;
  logic [STEP_BITS-1:0] quo;

  // restoring division over the top byte of the working word
  always_comb begin
    part = rem;
    quo  = '0;
    trial = '0;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      trial = {part, work[PAD_BITS-STEP_BITS+i]};
      if (trial >= radix) begin
        quo[i] = 1'b1;
        part   = DIGIT_W'(trial - radix);
      end else begin
        part   = trial[DIGIT_W-1:0];
      end
    end
    work_next = (work << STEP_BITS) | PAD_BITS'(quo);
  end

  // pass counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        active <= 1'b1;
        cnt    <= CNT_W'(CHUNKS - 1);
      end else if (active) begin
        if (cnt == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // working word, remainder and divisor
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= '0;
      if (ctrl.load) begin
        work  <= PAD_BITS'(value_in);
        radix <= radix_in;
      end
    end else if (active) begin
      work <= work_next;
      rem  <= part;
    end
  end

  assign stat.done = done;
  assign stat.zero = (work == '0);
  assign digit     = rem;

endmodule

FILE: rtl/integer_to_radix_digits.sv
// Converts an integer to ASCII digits, least significant first, one transfer per digit.
// Each digit comes from the shared divider, which retires eight quotient bits per cycle,
// and is then held on the output while out_stall is high. Input is stalled from acceptance
// until the last digit leaves. Synchronous active-high reset returns the sequencer to idle
// with no output pending.
module integer_to_radix_digits #(
  parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic [itrd_pkg::VALUE_W-1:0]  value,
  input  logic [itrd_pkg::RADIX_W-1:0]  radix,
  input  logic                          upper_case,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [itrd_pkg::CHAR_W-1:0]   digit_char,
  output logic                          last,
  output logic                          negative,
  output logic [itrd_pkg::LEN_W-1:0]    length
);
  `include "assert_macros.svh"
  import itrd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t                state;
  state_t                state_next;
  logic                  neg;
  logic                  upper;
  logic [LEN_W-1:0]      count;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  logic                  in_neg;
  logic [RADIX_W-1:0]    radix_clamped;
  logic                  in_xfer;
  logic                  out_xfer;
  div_ctrl_t             div_ctrl;
  div_stat_t             div_stat;
  logic [DIGIT_W-1:0]    div_digit;

  // magnitude and clamped base of the incoming item
  always_comb begin
    raw    = value[VALUE_BITS-1:0];
    in_neg = op & raw[VALUE_BITS-1];
    mag    = in_neg ? (~raw + 1'b1) : raw;
    if (radix < RADIX_MIN) begin
      radix_clamped = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      radix_clamped = RADIX_MAX;
    end else begin
      radix_clamped = radix;
    end
  end

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid & ~in_stall;
  assign out_xfer = out_valid & ~out_stall;

  // divider start: new item, or next digit after a transfer
  always_comb begin
    div_ctrl.load  = (state == S_IDLE) & in_xfer;
    div_ctrl.start = div_ctrl.load | ((state == S_EMIT) & out_xfer & ~last);
  end

  itrd_div_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .value_in (mag),
    .radix_in (radix_clamped),
    .stat     (div_stat),
    .digit    (div_digit)
  );

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) state_next = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_xfer) state_next = last ? S_IDLE : S_DIV;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      state <= state_next;
      if (in_xfer) begin
        count <= '0;
      end else if ((state == S_EMIT) & out_xfer) begin
        count <= count + 1'b1;
      end
      if ((state == S_DIV) & div_stat.done) begin
        out_valid <= 1'b1;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item attributes and output payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      neg   <= in_neg;
      upper <= upper_case;
    end
    if ((state == S_DIV) & div_stat.done) begin
      digit_char <= digit_to_ascii(div_digit, upper);
      last       <= div_stat.zero;
      negative   <= div_stat.zero & neg;
      length     <= div_stat.zero ? (count + LEN_W'(1) + LEN_W'(neg)) : '0;
    end
  end

  `ITRD_ASSERT_IMP(a_out_while_busy, clk, rst, out_valid, in_stall)
  `ITRD_ASSERT_IMP(a_early_fields, clk, rst, out_valid && !last, !negative && length == '0)
  `ITRD_ASSERT_NXT(a_accept_no_out, clk, rst, in_valid && !in_stall, !out_valid)
  `ITRD_ASSERT_NXT(a_last_to_idle, clk, rst, out_valid && !out_stall && last, !in_stall)

endmodule

FILE: dv/tb.sv
// testbench for integer_to_radix_digits: checks each digit transfer against a local predictor
`timescale 1ns / 100ps

module tb;
  import itrd_pkg::*;

  localparam logic OP_UNSIGNED = 1'b0;
  localparam logic OP_SIGNED   = 1'b1;

  localparam int RANDOM_ITEMS   = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  // digit tables, character 0 in the top byte
  localparam logic [8*16-1:0] UPPER_TAB = "0123456789ABCDEF";
  localparam logic [8*16-1:0] LOWER_TAB = "0123456789abcdef";

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              is_last;
    logic              is_neg;
    logic [LEN_W-1:0]  count;
  } digit_t;

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic                 op         = OP_UNSIGNED;
  logic [VALUE_W-1:0]   value      = '0;
  logic [RADIX_W-1:0]   radix      = RADIX_MIN;
  logic                 upper_case = 1'b0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [CHAR_W-1:0]    digit_char;
  logic                 last;
  logic                 negative;
  logic [LEN_W-1:0]     length;

  digit_t      pending_digits[$];
  digit_t      got_digit;
  int          errors      = 0;
  int          idle_cycles = 0;
  stall_mode_t stall_mode  = STALL_NONE;
  int          stall_left  = 0;

  integer_to_radix_digits i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .value      (value),
    .radix      (radix),
    .upper_case (upper_case),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit_char (digit_char),
    .last       (last),
    .negative   (negative),
    .length     (length)
  );

  always #1 clk = ~clk;

  // digits of one number, least significant first, appended to the expected queue
  function automatic void predict_digits(input logic is_signed_op,
                                         input logic [VALUE_W-1:0] v,
                                         input logic [RADIX_W-1:0] r,
                                         input logic upper);
    digit_t             digits[$];
    digit_t             cur;
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] base;
    logic [VALUE_W-1:0] rem;
    logic [3:0]         idx;
    logic               neg;
    if (r < RADIX_MIN) begin
      base = VALUE_W'(RADIX_MIN);
    end else if (r > RADIX_MAX) begin
      base = VALUE_W'(RADIX_MAX);
    end else begin
      base = VALUE_W'(r);
    end
    // negative signed values convert as their magnitude; the most negative wraps onto itself
    neg = (is_signed_op == OP_SIGNED) && v[VALUE_W-1];
    mag = neg ? (~v + 1'b1) : v;
    do begin
      rem = mag % base;
      mag = mag / base;
      idx = rem[3:0];
      cur.ch = upper ? UPPER_TAB[8*(15-idx) +: CHAR_W] : LOWER_TAB[8*(15-idx) +: CHAR_W];
      cur.is_last = 1'b0;
      cur.is_neg = 1'b0;
      cur.count = '0;
      digits.push_back(cur);
    end while (mag != 0 && digits.size() < 64);
    // sign and character count ride on the final digit only
    digits[digits.size()-1].is_last = 1'b1;
    digits[digits.size()-1].is_neg = neg;
    digits[digits.size()-1].count = LEN_W'(digits.size() + (neg ? 1 : 0));
    foreach (digits[i]) pending_digits.push_back(digits[i]);
  endfunction

  // one input transfer; holds the payload until accepted
  task automatic send_number(input logic o, input logic [VALUE_W-1:0] v,
                             input logic [RADIX_W-1:0] r, input logic u);
    @(negedge clk);
    in_valid <= 1'b1;
    op <= o;
    value <= v;
    radix <= r;
    upper_case <= u;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_digits(o, v, r, u);
  endtask

  task automatic pause_sender(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // hold off the sender until every expected digit is out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
  endtask

  // values biased toward edges, short numbers and long numbers
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: pick_value = v;
      1: pick_value = VALUE_W'($urandom_range(0, 255));
      2: pick_value = v >> $urandom_range(0, 63);
      3: pick_value = ~VALUE_W'($urandom_range(0, 1000)) + 1'b1;
      4: pick_value = (VALUE_W'(1) << $urandom_range(0, 63)) - VALUE_W'($urandom_range(0, 1));
      default: pick_value = {$urandom_range(0, 1) ? 1'b1 : 1'b0,
                             {(VALUE_W-1){$urandom_range(0, 1) ? 1'b1 : 1'b0}}}
                            ^ VALUE_W'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [RADIX_W-1:0] pick_radix();
    if ($urandom_range(0, 9) == 0) begin
      pick_radix = RADIX_W'($urandom_range(0, 31));
    end else begin
      pick_radix = RADIX_W'($urandom_range(2, 16));
    end
  endfunction

  // zero, all ones, most negative and most positive values, and fifteen in base sixteen
  task automatic test_extremes();
    send_number(OP_UNSIGNED, '0, 5'd10, 1'b0);
    send_number(OP_SIGNED, '0, 5'd16, 1'b1);
    send_number(OP_UNSIGNED, '1, 5'd2, 1'b0);
    send_number(OP_SIGNED, '1, 5'd10, 1'b0);
    send_number(OP_SIGNED, {1'b1, {(VALUE_W-1){1'b0}}}, 5'd2, 1'b0);
    send_number(OP_SIGNED, {1'b1, {(VALUE_W-1){1'b0}}}, 5'd16, 1'b1);
    send_number(OP_SIGNED, {1'b0, {(VALUE_W-1){1'b1}}}, 5'd10, 1'b0);
    send_number(OP_UNSIGNED, '1, 5'd16, 1'b1);
    send_number(OP_UNSIGNED, '1, 5'd10, 1'b0);
    send_number(OP_UNSIGNED, 64'd15, 5'd16, 1'b1);
  endtask

  // radix below two and above sixteen
  task automatic test_radix_clamp();
    send_number(OP_UNSIGNED, 64'd1000, 5'd0, 1'b0);
    send_number(OP_SIGNED, -64'sd77, 5'd1, 1'b0);
    send_number(OP_UNSIGNED, 64'hBEEF, 5'd17, 1'b1);
    send_number(OP_UNSIGNED, 64'hCAFE_F00D, 5'd31, 1'b0);
  endtask

  // letter digits in both cases and odd bases
  task automatic test_letter_case();
    send_number(OP_UNSIGNED, 64'hFEDC_BA98_7654_3210, 5'd16, 1'b1);
    send_number(OP_UNSIGNED, 64'hFEDC_BA98_7654_3210, 5'd16, 1'b0);
    send_number(OP_SIGNED, 64'hFEDC_BA98_7654_3210, 5'd13, 1'b1);
    send_number(OP_UNSIGNED, 64'd123456789, 5'd11, 1'b0);
  endtask

  // a sender pause until the converter is fully idle
  task automatic test_idle_pause();
    send_number(OP_SIGNED, -64'sd42, 5'd3, 1'b0);
    wait_drained();
    send_number(OP_UNSIGNED, 64'd42, 5'd3, 1'b1);
  endtask

  // random numbers sent in bursts
  task automatic test_random();
    int sent;
    int burst;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 6);
      for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        send_number($urandom_range(0, 1) ? OP_SIGNED : OP_UNSIGNED, pick_value(),
                    pick_radix(), $urandom_range(0, 1) ? 1'b1 : 1'b0);
        sent++;
      end
      if ($urandom_range(0, 9) == 0) begin
        pause_sender($urandom_range(20, 60));
      end else if ($urandom_range(0, 2) != 0) begin
        pause_sender($urandom_range(1, 5));
      end
    end
  endtask

  // receiver stall pattern, changing mode whenever stall_left runs out
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(64, 256);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ~out_stall;
    endcase
  end

  // compare each digit transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_digits.size() == 0) begin
        errors++;
        $error("unexpected digit transfer: digit_char %0h", digit_char);
      end else begin
        got_digit = pending_digits.pop_front();
        if (digit_char !== got_digit.ch) begin
          errors++;
          $error("digit_char: expected %0h, got %0h", got_digit.ch, digit_char);
        end
        if (last !== got_digit.is_last) begin
          errors++;
          $error("last: expected %0b, got %0b", got_digit.is_last, last);
        end
        if (negative !== got_digit.is_neg) begin
          errors++;
          $error("negative: expected %0b, got %0b", got_digit.is_neg, negative);
        end
        if (length !== got_digit.count) begin
          errors++;
          $error("length: expected %0d, got %0d", got_digit.count, length);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles < WATCHDOG_LIMIT) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_extremes();
    test_radix_clamp();
    test_letter_case();
    test_idle_pause();
    test_random();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_digits.size() != 0) begin
      errors++;
      $error("%0d expected digits never arrived", pending_digits.size());
    end
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/itrd_pkg.sv
rtl/itrd_div_unit.sv
rtl/integer_to_radix_digits.sv
dv/tb.sv
